// ===== src/great_circle_distance_core_assert.svh =====
// Assertion macros for the distance core.
`ifndef GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GCD_ASSERT(label, prop, msg)
`define GCD_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== src/gcd_pkg.sv =====
package gcd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 34;
  localparam int SQN       = 31;
  localparam int SQW       = 2 * SQN;
  localparam int SUMW      = 52;
  localparam int DEG_SHIFT = FRAC_BITS + 3;
  localparam int KM_SHIFT  = 30 - FRAC_BITS;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_EUCLID    = 2'd0;
  localparam mode_t MODE_HAVERSINE = 2'd1;

  localparam logic signed [CW-1:0] GAIN_INV_Q30   = 34'sd652032874;
  localparam logic signed [27:0]   DEG_TO_RAD_Q32 = 28'sd74961321;
  localparam logic [13:0]          EARTH_DIAM_KM  = 14'd12742;
  localparam logic signed [26:0]   FULL_TURN      = 27'(360 << (FRAC_BITS + 1));
  localparam logic signed [26:0]   HALF_TURN      = 27'(180 << (FRAC_BITS + 1));
  localparam logic signed [26:0]   QUARTER_TURN   = 27'(90 << (FRAC_BITS + 1));
  localparam logic [30:0]          ONE_Q30        = 31'h4000_0000;
  localparam logic [45:0]          KM_ROUND       = 46'd1 << (KM_SHIFT - 1);
  localparam logic [31:0]          NEG_ONE        = ~((32'd1 << FRAC_BITS) - 32'd1);

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] a;
    case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837830;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      5'd24: a = 34'sd64;
      5'd25: a = 34'sd32;
      5'd26: a = 34'sd16;
      5'd27: a = 34'sd8;
      5'd28: a = 34'sd4;
      5'd29: a = 34'sd2;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/gcd_cordic.sv =====
module gcd_cordic
  import gcd_pkg::*;
#(
  parameter int STEPS     = 20,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z
);

  logic signed [CW-1:0] x_r [STEPS];
  logic signed [CW-1:0] y_r [STEPS];
  logic signed [CW-1:0] z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi, dx, dy, ang;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_first
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end

    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign ang = atan_q30(5'(i));

    always_comb begin
      x_nxt = xi;
      y_nxt = yi;
      z_nxt = zi;
      if (VECTORING) begin
        if (yi > 0) begin
          x_nxt = xi + dx;
          y_nxt = yi - dy;
          z_nxt = zi + ang;
        end else if (yi < 0) begin
          x_nxt = xi - dx;
          y_nxt = yi + dy;
          z_nxt = zi - ang;
        end
      end else begin
        if (zi >= 0) begin
          x_nxt = xi - dx;
          y_nxt = yi + dy;
          z_nxt = zi - ang;
        end else begin
          x_nxt = xi + dx;
          y_nxt = yi - dy;
          z_nxt = zi + ang;
        end
      end
    end

    always_ff @(posedge clk) begin
      x_r[i] <= x_nxt;
      y_r[i] <= y_nxt;
      z_r[i] <= z_nxt;
    end
  end

  assign out_x = x_r[STEPS-1];
  assign out_y = y_r[STEPS-1];
  assign out_z = z_r[STEPS-1];

endmodule

// ===== src/great_circle_distance_core.sv =====
// Channel  | Handshake          | Payload
// request  | start / busy       | in_first_longitude .. in_second_latitude
// result   | out_strobe         | out_point_distance
// config   | cfg_we             | cfg_wdata (distance mode)
//
// One request per cycle; busy stays low.
// The datapath runs four parallel rotation CORDICs, then two parallel 31-stage
// square roots, then one vectoring CORDIC.
// Reset clears the valid pipe and sets the mode to euclidean.
// Results leave on a one-cycle strobe; nothing upstream stalls.
`include "great_circle_distance_core_assert.svh"

module great_circle_distance_core
  import gcd_pkg::*;
#(
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [24:0] in_first_longitude,
  input  logic signed [23:0] in_first_latitude,
  input  logic signed [24:0] in_second_longitude,
  input  logic signed [23:0] in_second_latitude,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  output logic               out_strobe,
  output logic signed [31:0] out_point_distance
);

  localparam int LAT = 7 + SQN + 2 * CORDIC_STEPS;

  typedef struct packed {
    mode_t           mode;
    logic            flip1;
    logic            flip2;
    logic [SUMW-1:0] sum;
  } rot_side_t;

  typedef struct packed {
    mode_t          mode;
    logic [SQN-1:0] root;
  } vec_side_t;

  mode_t           mode_r;
  logic [LAT-1:0]  vld_r;

  logic signed [25:0]    ang_p1_r [4];
  logic signed [25:0]    ang_p1_nxt [4];
  mode_t                 mode_p1_r;
  logic signed [24:0]    ang_p2_r [4];
  logic signed [24:0]    ang_p2_nxt [4];
  logic                  flip_p2_r [4];
  logic                  flip_p2_nxt [4];
  logic [SUMW-1:0]       sqx_p2_r, sqy_p2_r;
  mode_t                 mode_p2_r;
  logic signed [CW-1:0]  z_p3_r [4];
  logic signed [CW-1:0]  z_p3_nxt [4];
  rot_side_t             side_p3_r;
  rot_side_t             rot_side_r [CORDIC_STEPS];
  logic signed [CW-1:0]  rot_x [4];
  logic signed [CW-1:0]  rot_y [4];

  logic signed [CW-1:0]  p1_m1_r, p2_m1_r, p3_m1_r;
  rot_side_t             side_m1_r;
  logic signed [CW-1:0]  p1_m2_r, p4_m2_r;
  mode_t                 mode_m2_r;
  logic [SUMW-1:0]       sum_m2_r;
  logic [SQW-1:0]        rad_r [2];
  mode_t                 mode_m3_r;

  logic [SQW-1:0]        rem_r [2][SQN-1];
  logic [SQN-1:0]        root_r [2][SQN];
  mode_t                 mode_sq_r [SQN];
  vec_side_t             vec_side_r [CORDIC_STEPS];
  logic signed [CW-1:0]  vec_z;

  logic signed [31:0]    out_pd_r, out_pd_nxt;
  mode_t                 out_mode_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EUCLID;
      vld_r  <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  always_comb begin
    ang_p1_nxt[0] = 26'(in_second_latitude) - 26'(in_first_latitude);
    ang_p1_nxt[1] = 26'(in_second_longitude) - 26'(in_first_longitude);
    ang_p1_nxt[2] = 26'(in_first_latitude) <<< 1;
    ang_p1_nxt[3] = 26'(in_second_latitude) <<< 1;
  end

  always_ff @(posedge clk) begin
    ang_p1_r  <= ang_p1_nxt;
    mode_p1_r <= mode_r;
  end

  always_comb begin
    logic signed [26:0] v, r0, r1, rf;
    logic               fl;
    for (int k = 0; k < 4; k++) begin
      v  = 27'(ang_p1_r[k]);
      r0 = (v < 0) ? v + FULL_TURN : v;
      r1 = (r0 > HALF_TURN) ? r0 - FULL_TURN : r0;
      if (r1 > QUARTER_TURN) begin
        rf = HALF_TURN - r1;
        fl = 1'b1;
      end else if (r1 < -QUARTER_TURN) begin
        rf = -HALF_TURN - r1;
        fl = 1'b1;
      end else begin
        rf = r1;
        fl = 1'b0;
      end
      ang_p2_nxt[k]  = 25'(rf);
      flip_p2_nxt[k] = fl;
    end
  end

  always_ff @(posedge clk) begin
    ang_p2_r  <= ang_p2_nxt;
    flip_p2_r <= flip_p2_nxt;
    sqx_p2_r  <= SUMW'(ang_p1_r[1] * ang_p1_r[1]);
    sqy_p2_r  <= SUMW'(ang_p1_r[0] * ang_p1_r[0]);
    mode_p2_r <= mode_p1_r;
  end

  always_comb begin
    logic signed [52:0] zp;
    for (int k = 0; k < 4; k++) begin
      zp          = 53'(ang_p2_r[k]) * 53'(DEG_TO_RAD_Q32);
      z_p3_nxt[k] = zp[DEG_SHIFT+CW-1:DEG_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    z_p3_r          <= z_p3_nxt;
    side_p3_r.mode  <= mode_p2_r;
    side_p3_r.flip1 <= flip_p2_r[2];
    side_p3_r.flip2 <= flip_p2_r[3];
    side_p3_r.sum   <= sqx_p2_r + sqy_p2_r;
  end

  for (genvar k = 0; k < 4; k++) begin : g_rot
    gcd_cordic #(
      .STEPS     (CORDIC_STEPS),
      .VECTORING (1'b0)
    ) u_rot (
      .clk   (clk),
      .in_x  (GAIN_INV_Q30),
      .in_y  ('0),
      .in_z  (z_p3_r[k]),
      .out_x (rot_x[k]),
      .out_y (rot_y[k]),
      .out_z ()
    );
  end

  always_ff @(posedge clk) begin
    rot_side_r[0] <= side_p3_r;
    for (int s = 1; s < CORDIC_STEPS; s++) begin
      rot_side_r[s] <= rot_side_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW-1:0]   c1, c2;
    logic signed [2*CW-1:0] pa, pb, pc;
    c1 = rot_side_r[CORDIC_STEPS-1].flip1 ? -rot_x[2] : rot_x[2];
    c2 = rot_side_r[CORDIC_STEPS-1].flip2 ? -rot_x[3] : rot_x[3];
    pa = rot_y[0] * rot_y[0];
    pb = c1 * c2;
    pc = rot_y[1] * rot_y[1];
    p1_m1_r   <= pa[30+CW-1:30];
    p2_m1_r   <= pb[30+CW-1:30];
    p3_m1_r   <= pc[30+CW-1:30];
    side_m1_r <= rot_side_r[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk) begin
    logic signed [2*CW-1:0] pd;
    pd = p2_m1_r * p3_m1_r;
    p1_m2_r   <= p1_m1_r;
    p4_m2_r   <= pd[30+CW-1:30];
    mode_m2_r <= side_m1_r.mode;
    sum_m2_r  <= side_m1_r.sum;
  end

  always_ff @(posedge clk) begin
    logic signed [CW:0] h;
    logic [30:0]        hc;
    h = (CW+1)'(p1_m2_r) + (CW+1)'(p4_m2_r);
    if (h < 0) begin
      hc = '0;
    end else if (h > (CW+1)'(ONE_Q30)) begin
      hc = ONE_Q30;
    end else begin
      hc = h[30:0];
    end
    rad_r[0]  <= (mode_m2_r == MODE_EUCLID) ? SQW'(sum_m2_r) : SQW'({hc, 30'd0});
    rad_r[1]  <= SQW'({ONE_Q30 - hc, 30'd0});
    mode_m3_r <= mode_m2_r;
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < SQN; s++) begin : g_bit
      localparam int K = SQN - 1 - s;
      logic [SQW-1:0] rem_i, rem_nxt;
      logic [SQN-1:0] root_i, root_nxt;
      logic [SQW:0]   trial;

      if (s == 0) begin : g_first
        assign rem_i  = rad_r[l];
        assign root_i = '0;
      end else begin : g_next
        assign rem_i  = rem_r[l][s-1];
        assign root_i = root_r[l][s-1];
      end

      always_comb begin
        trial    = ((SQW+1)'(root_i) << (K + 1)) | ((SQW+1)'(1) << (2 * K));
        rem_nxt  = rem_i;
        root_nxt = root_i;
        if ({1'b0, rem_i} >= trial) begin
          rem_nxt  = SQW'({1'b0, rem_i} - trial);
          root_nxt = root_i | (SQN'(1) << K);
        end
      end

      always_ff @(posedge clk) begin
        root_r[l][s] <= root_nxt;
      end

      if (s < SQN - 1) begin : g_rem
        always_ff @(posedge clk) begin
          rem_r[l][s] <= rem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_sq_r[0] <= mode_m3_r;
    for (int s = 1; s < SQN; s++) begin
      mode_sq_r[s] <= mode_sq_r[s-1];
    end
  end

  gcd_cordic #(
    .STEPS     (CORDIC_STEPS),
    .VECTORING (1'b1)
  ) u_vec (
    .clk   (clk),
    .in_x  (CW'(root_r[1][SQN-1])),
    .in_y  (CW'(root_r[0][SQN-1])),
    .in_z  ('0),
    .out_x (),
    .out_y (),
    .out_z (vec_z)
  );

  always_ff @(posedge clk) begin
    vec_side_r[0].mode <= mode_sq_r[SQN-1];
    vec_side_r[0].root <= root_r[0][SQN-1];
    for (int s = 1; s < CORDIC_STEPS; s++) begin
      vec_side_r[s] <= vec_side_r[s-1];
    end
  end

  always_comb begin
    logic [30:0] zc;
    logic [45:0] km;
    zc = (vec_z < 0) ? '0 : vec_z[30:0];
    km = 46'(zc) * 46'(EARTH_DIAM_KM) + KM_ROUND;
    unique case (vec_side_r[CORDIC_STEPS-1].mode)
      MODE_EUCLID:    out_pd_nxt = 32'(vec_side_r[CORDIC_STEPS-1].root);
      MODE_HAVERSINE: out_pd_nxt = km[KM_SHIFT+31:KM_SHIFT];
      default:        out_pd_nxt = NEG_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_pd_r   <= out_pd_nxt;
    out_mode_r <= vec_side_r[CORDIC_STEPS-1].mode;
  end

  assign out_strobe         = vld_r[LAT-1];
  assign out_point_distance = out_pd_r;

  `GCD_ASSERT(a_strobe_follows_start, out_strobe |-> $past(start, LAT), "result without request")
  `GCD_ASSERT(a_euclid_range, (out_strobe && out_mode_r == MODE_EUCLID) |-> (out_point_distance[31:26] == 6'd0), "euclidean result too wide")
  `GCD_ASSERT(a_unknown_mode, (out_strobe && out_mode_r != MODE_EUCLID && out_mode_r != MODE_HAVERSINE) |-> (out_point_distance == NEG_ONE), "unknown mode must give -1")
  `GCD_ASSERT(a_haversine_sign, (out_strobe && out_mode_r == MODE_HAVERSINE) |-> !out_point_distance[31], "negative haversine distance")
  `GCD_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_strobe, "strobe right after reset")

endmodule
